// ===== design/mosa_pkg.sv =====
// ============================================================================
// mosa_pkg
// shared constants, codes and controller/datapath interface types for the
// median-of-two-sorted-sequences block
// ============================================================================
`default_nettype none

package mosa_pkg;

    // storage geometry
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // word field widths
    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int MED_W  = 33;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_MEDIAN        = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOPART  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic append;   // append word accepted
        logic setup;    // pick roles, init search bounds
        logic rd_lo;    // issue reads of left neighbors
        logic rd_hi;    // capture left, issue reads of right neighbors
        logic eval;     // compare partition, narrow bounds
        logic publish;  // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // both sequences empty
        logic exhausted; // search bounds crossed
        logic found;     // partition satisfied
        logic out_free;  // output register can take a result
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/mosa_ram.sv =====
// ============================================================================
// mosa_ram
// generic simple dual-port ram, one write port, one registered read port
// ============================================================================
`default_nettype none

module mosa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/mosa_ctrl.sv =====
// ============================================================================
// mosa_ctrl
// sequencer for appends and the partition binary search
// ============================================================================
`default_nettype none

module mosa_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [mosa_pkg::OP_W-1:0] i_operation,
    output      logic                      o_in_stall,
    input  wire mosa_pkg::t_dp_sts         i_sts,
    output      mosa_pkg::t_dp_cmd         o_cmd
);

    import mosa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RD_LO = 3'd2;
    localparam logic [2:0] S_RD_HI = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.append  = accept &&
                        (i_operation inside {OP_APPEND_FIRST, OP_APPEND_SECOND});
        o_cmd.setup   = (r_state == S_SETUP);
        o_cmd.rd_lo   = (r_state == S_RD_LO);
        o_cmd.rd_hi   = (r_state == S_RD_HI);
        o_cmd.eval    = (r_state == S_EVAL);
        o_cmd.publish = (r_state == S_OUT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_operation == OP_MEDIAN)) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = i_sts.empty ? S_OUT : S_RD_LO;
            end
            S_RD_LO: begin
                n_state = i_sts.exhausted ? S_OUT : S_RD_HI;
            end
            S_RD_HI: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.found ? S_OUT : S_RD_LO;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/mosa_dp.sv =====
// ============================================================================
// mosa_dp
// element stores, counts, search bounds, partition compare and output register
// ============================================================================
`default_nettype none

module mosa_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [mosa_pkg::OP_W-1:0]          i_operation,
    input  wire logic signed [mosa_pkg::DATA_W-1:0] i_value,
    input  wire logic                               i_out_stall,
    input  wire mosa_pkg::t_dp_cmd                  i_cmd,
    output      mosa_pkg::t_dp_sts                  o_sts,
    output      logic                               o_out_valid,
    output      logic signed [mosa_pkg::MED_W-1:0]  o_median_doubled,
    output      logic [mosa_pkg::STAT_W-1:0]        o_status
);

    import mosa_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STORE_DEPTH);

    // fill counts and drop flag
    logic [CNT_W-1:0] r_first_cnt, r_second_cnt;
    logic             r_drop;

    // search state
    logic             r_swap;
    logic [CNT_W-1:0] r_n, r_m, r_half;
    logic             r_odd;
    logic [CNT_W-1:0] r_lo, r_lim;  // search range is [lo, lim)
    logic [CNT_W-1:0] r_px, r_py;
    logic             r_x1_neg, r_x2_pos, r_y1_neg, r_y2_pos;
    logic signed [DATA_W-1:0] r_x1, r_y1;

    // pending result and output register
    logic signed [MED_W-1:0]  r_res_med;
    logic [STAT_W-1:0]        r_res_st;
    logic                     r_out_valid;
    logic signed [MED_W-1:0]  r_out_med;
    logic [STAT_W-1:0]        r_out_st;

    // ram ports
    logic                     we_first, we_second;
    logic [ADDR_W-1:0]        raddr_first, raddr_second;
    logic [DATA_W-1:0]        rdata_first, rdata_second;
    logic [ADDR_W-1:0]        addr_short, addr_long;
    logic signed [DATA_W-1:0] x2, y2;

    // next values
    logic [CNT_W:0]           n_mid_sum;
    logic [CNT_W-1:0]         n_px, n_py, n_px_m1, n_py_m1;
    logic                     n_swap;
    logic [CNT_W-1:0]         n_short_cnt, n_long_cnt;
    logic [CNT_W:0]           n_total_p1;
    logic                     le_x1_y2, le_y1_x2, found;
    logic signed [DATA_W-1:0] lmax, rmin;
    logic signed [MED_W-1:0]  n_med;

    assign we_first  = i_cmd.append && (i_operation == OP_APPEND_FIRST) &&
                       (r_first_cnt < FULL_CNT);
    assign we_second = i_cmd.append && (i_operation == OP_APPEND_SECOND) &&
                       (r_second_cnt < FULL_CNT);

    // midpoint of [lo, lim), only used while lo < lim
    assign n_mid_sum = {1'b0, r_lo} + {1'b0, r_lim} - {{CNT_W{1'b0}}, 1'b1};
    assign n_px      = n_mid_sum[CNT_W:1];
    assign n_py      = r_half - n_px;
    assign n_px_m1   = n_px - {{(CNT_W-1){1'b0}}, 1'b1};
    assign n_py_m1   = n_py - {{(CNT_W-1){1'b0}}, 1'b1};

    assign addr_short   = i_cmd.rd_lo ? n_px_m1[ADDR_W-1:0] : r_px[ADDR_W-1:0];
    assign addr_long    = i_cmd.rd_lo ? n_py_m1[ADDR_W-1:0] : r_py[ADDR_W-1:0];
    assign raddr_first  = r_swap ? addr_long : addr_short;
    assign raddr_second = r_swap ? addr_short : addr_long;

    mosa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (r_first_cnt[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (raddr_first),
        .o_rdata (rdata_first)
    );

    mosa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (r_second_cnt[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (raddr_second),
        .o_rdata (rdata_second)
    );

    // read data by role
    assign x2 = r_swap ? rdata_second : rdata_first;
    assign y2 = r_swap ? rdata_first : rdata_second;

    // role choice: first plays the shorter one on a tie
    assign n_swap      = (r_first_cnt > r_second_cnt);
    assign n_short_cnt = n_swap ? r_second_cnt : r_first_cnt;
    assign n_long_cnt  = n_swap ? r_first_cnt : r_second_cnt;
    assign n_total_p1  = {1'b0, r_first_cnt} + {1'b0, r_second_cnt} +
                         {{CNT_W{1'b0}}, 1'b1};

    // partition test, missing neighbors act as -inf / +inf
    assign le_x1_y2 = r_x1_neg || r_y2_pos || (r_x1 <= y2);
    assign le_y1_x2 = r_y1_neg || r_x2_pos || (r_y1 <= x2);
    assign found    = le_x1_y2 && le_y1_x2;

    assign lmax = r_x1_neg ? r_y1 :
                  r_y1_neg ? r_x1 :
                  (r_x1 > r_y1) ? r_x1 : r_y1;
    assign rmin = r_x2_pos ? y2 :
                  r_y2_pos ? x2 :
                  (x2 < y2) ? x2 : y2;
    assign n_med = r_odd ? {lmax, 1'b0} : (MED_W'(lmax) + MED_W'(rmin));

    assign o_sts.empty     = (r_first_cnt == '0) && (r_second_cnt == '0);
    assign o_sts.exhausted = !(r_lo < r_lim);
    assign o_sts.found     = found;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_drop       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.append) begin
                if (i_operation == OP_APPEND_FIRST) begin
                    if (we_first) r_first_cnt <= r_first_cnt + 1'b1;
                    else          r_drop      <= 1'b1;
                end else begin
                    if (we_second) r_second_cnt <= r_second_cnt + 1'b1;
                    else           r_drop       <= 1'b1;
                end
            end
            if (i_cmd.publish) begin
                r_out_valid  <= 1'b1;
                r_first_cnt  <= '0;
                r_second_cnt <= '0;
                r_drop       <= 1'b0;
            end
        end
    end

    // search and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_swap    <= n_swap;
            r_n       <= n_short_cnt;
            r_m       <= n_long_cnt;
            r_half    <= n_total_p1[CNT_W:1];
            r_odd     <= r_first_cnt[0] ^ r_second_cnt[0];
            r_lo      <= '0;
            r_lim     <= n_short_cnt + 1'b1;
            r_res_med <= '0;
            r_res_st  <= ST_EMPTY;
        end
        if (i_cmd.rd_lo) begin
            r_px      <= n_px;
            r_py      <= n_py;
            r_x1_neg  <= (n_px == '0);
            r_x2_pos  <= (n_px == r_n);
            r_y1_neg  <= (n_py == '0);
            r_y2_pos  <= (n_py == r_m);
            r_res_med <= -MED_W'(2);
            r_res_st  <= ST_NOPART;
        end
        if (i_cmd.rd_hi) begin
            r_x1 <= x2;
            r_y1 <= y2;
        end
        if (i_cmd.eval) begin
            if (found) begin
                r_res_med <= n_med;
                r_res_st  <= r_drop ? ST_DROPPED : ST_OK;
            end else if (!le_x1_y2) begin
                r_lim <= r_px;
            end else begin
                r_lo <= r_px + 1'b1;
            end
        end
        if (i_cmd.publish) begin
            r_out_med <= r_res_med;
            r_out_st  <= r_res_st;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_median_doubled = r_out_med;
    assign o_status         = r_out_st;

endmodule

`default_nettype wire

// ===== design/median_of_two_sorted_arrays_top.sv =====
// ============================================================================
// median_of_two_sorted_arrays_top
// median of two ascending signed sequences by partition binary search
// ============================================================================
// usage:
//   input channel (i_in_valid / o_in_stall) carries one word: i_operation and
//   i_value. append-to-first and append-to-second words are taken one per
//   cycle while the block is idle; a full store ignores the element and marks
//   the next found result as dropped. a median word starts the search and yields
//   one result word; other operation codes are taken and ignored.
//   output channel (o_out_valid / i_out_stall) carries o_median_doubled (twice
//   the median, 33-bit signed) and o_status, held in an output register.
// search:
//   a median word runs k search steps, k at most floor(log2(shorter length
//   + 1)) + 1, each two reads plus one compare, and then moves its result
//   into the output register; o_in_stall stays high until the result is
//   published.
// reset (synchronous, active low): counts and drop flag clear, output empty;
//   store contents are not cleared, only entries below a count are read.
// receiver stall: the result holds in the output register; appends are still
//   taken meanwhile, a next median request waits at the publish step.
// ============================================================================
`default_nettype none

module median_of_two_sorted_arrays_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input words
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire logic [mosa_pkg::OP_W-1:0]          i_operation,
    input  wire logic signed [mosa_pkg::DATA_W-1:0] i_value,
    // result words
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      logic signed [mosa_pkg::MED_W-1:0]  o_median_doubled,
    output      logic [mosa_pkg::STAT_W-1:0]        o_status
);

    import mosa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: idle accept, role setup, read/read/compare per step, publish
    mosa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, counts, search registers, compare and output register
    mosa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_median_doubled (o_median_doubled),
        .o_status         (o_status)
    );

    // empty request always reports zero
    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_median_doubled == '0))
        else $error("empty result with nonzero median");

    // failed search always reports minus two
    a_nopart_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_NOPART)) |-> (o_median_doubled == -MED_W'(2)))
        else $error("failed search with wrong median");

    // a new result only follows a search that held the input off
    a_result_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a search");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top
// self-checking bench for the median-of-two-sorted-sequences block
// ============================================================================
// drives append, median and unused-code words through the input channel and
// checks every result word against an in-bench partition-search predictor
// kept in a scoreboard class. a short directed set covers the empty case,
// the 32-bit extremes, unsorted input and the unused operation code. random
// traffic then sends mostly sorted sequences with random content, a few
// unsorted ones and stray unused words. the first phase opens with a
// sequence that overruns the first store. both channels idle at random in
// the first two phases, with the mix changing per phase.
// ============================================================================

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mosa_pkg::*;

    // unused operation code, taken by the block and ignored
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // partition bounds beyond any 32-bit element
    localparam longint NEG_BOUND = -64'sd1099511627776;
    localparam longint POS_BOUND = 64'sd1099511627776;

    localparam int INT_MAX_V = 32'sh7FFF_FFFF;
    localparam int INT_MIN_V = 32'sh8000_0000;

    // cycles with no accepted word before the run is declared hung
    localparam int STUCK_LIMIT = 2000;
    // quiet cycles after the last result, longer than one full search
    localparam int DRAIN_CYCLES = 60;
    // random append/median words per phase, besides the overrun sequence
    localparam int PHASE_WORDS = 100;

    typedef struct {
        logic signed [MED_W-1:0] median;
        logic [STAT_W-1:0]       status;
    } t_median_word;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors both stores, predicts each median word and checks
    // the result words in order
    // ------------------------------------------------------------------------
    class median_tracker;
        logic signed [DATA_W-1:0] first_seq [STORE_DEPTH];
        logic signed [DATA_W-1:0] second_seq[STORE_DEPTH];
        int unsigned  first_len;
        int unsigned  second_len;
        bit           overflowed;
        t_median_word awaited[$];
        int unsigned  mismatches;

        // element of one store, or a bound past either end
        function longint element_at(bit from_first, longint idx, longint len,
                                    longint beyond);
            if (idx < 0)
                return NEG_BOUND;
            if (idx >= len)
                return beyond;
            return from_first ? longint'(first_seq[idx]) : longint'(second_seq[idx]);
        endfunction

        function t_median_word solve_median();
            t_median_word r;
            bit     short_first;
            longint n, m, lo, hi, px, py, half;
            longint x1, y1, x2, y2, left_max, right_min, twice;
            if (first_len == 0 && second_len == 0) begin
                r.median = '0;
                r.status = ST_EMPTY;
                return r;
            end
            // equal lengths leave the first store in the short role
            short_first = (first_len <= second_len);
            n = short_first ? first_len : second_len;
            m = short_first ? second_len : first_len;
            half = (n + m + 1) / 2;
            lo = 0;
            hi = n;
            while (lo <= hi) begin
                px = lo + (hi - lo) / 2;
                py = half - px;
                x1 = element_at(short_first, px - 1, n, NEG_BOUND);
                y1 = element_at(!short_first, py - 1, m, NEG_BOUND);
                x2 = element_at(short_first, px, n, POS_BOUND);
                y2 = element_at(!short_first, py, m, POS_BOUND);
                if (x1 <= y2 && y1 <= x2) begin
                    left_max  = (x1 > y1) ? x1 : y1;
                    right_min = (x2 < y2) ? x2 : y2;
                    twice = ((n + m) % 2 == 0) ? left_max + right_min : 2 * left_max;
                    r.median = twice[MED_W-1:0];
                    r.status = overflowed ? ST_DROPPED : ST_OK;
                    return r;
                end else if (x1 > y2) begin
                    hi = px - 1;
                end else begin
                    lo = px + 1;
                end
            end
            r.median = -33'sd2;
            r.status = ST_NOPART;
            return r;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
            case (op)
                OP_APPEND_FIRST: begin
                    if (first_len < STORE_DEPTH) begin
                        first_seq[first_len] = val;
                        first_len++;
                    end else begin
                        overflowed = 1'b1;
                    end
                end
                OP_APPEND_SECOND: begin
                    if (second_len < STORE_DEPTH) begin
                        second_seq[second_len] = val;
                        second_len++;
                    end else begin
                        overflowed = 1'b1;
                    end
                end
                OP_MEDIAN: begin
                    awaited.push_back(solve_median());
                    first_len  = 0;
                    second_len = 0;
                    overflowed = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [MED_W-1:0] med, logic [STAT_W-1:0] st);
            t_median_word want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word, median_doubled %0d status %0d",
                         $time, med, st);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (med !== want.median) begin
                $display("%0t: median_doubled expected %0d, got %0d",
                         $time, want.median, med);
                mismatches++;
            end
            if (st !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, st);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic [OP_W-1:0]          operation   = OP_APPEND_FIRST;
    logic signed [DATA_W-1:0] value       = '0;
    logic                     out_stall   = 1'b0;
    wire                      in_stall;
    wire                      out_valid;
    wire signed [MED_W-1:0]   median_doubled;
    wire [STAT_W-1:0]         status;

    median_tracker tracker;
    int unsigned   send_gap_pct;    // chance the sender idles before a word
    int unsigned   recv_stall_pct;  // chance the receiver stalls in a cycle
    int unsigned   words_sent;      // append and median words accepted
    int unsigned   stuck_cycles;

    initial begin
        forever #5 clk = ~clk;
    end

    median_of_two_sorted_arrays_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (operation),
        .i_value          (value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_median_doubled (median_doubled),
        .o_status         (status)
    );

    // ------------------------------------------------------------------------
    // result side: outputs are read at the edge before the block's own
    // updates land, so the values seen are the ones the edge accepts
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                tracker.check_result(median_doubled, status);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: any accepted word on either side restarts the count
    always @(posedge clk) begin
        if (!rst_n) begin
            stuck_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // called at a rising edge; returns at the edge that takes the word with
    // valid still high, so a following word can go out back to back
    task automatic send_word(input logic [OP_W-1:0] op, input int val);
        while ($urandom_range(99) < send_gap_pct) begin
            // junk payload while idle
            in_valid  <= 1'b0;
            operation <= OP_W'($urandom);
            value     <= $urandom;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_word(op, val);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // drop valid and wait until every predicted result word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    // element values: full range, a narrow band with many ties, or extremes
    function automatic int draw_value(int unsigned flavor);
        case (flavor)
            0: return int'($urandom);
            1: return int'($urandom_range(16)) - 8;
            default: begin
                case ($urandom_range(5))
                    0: return INT_MIN_V;
                    1: return INT_MIN_V + 1;
                    2: return INT_MAX_V;
                    3: return INT_MAX_V - 1;
                    4: return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // one sequence: appends to both stores in a random interleave, the odd
    // unused word in between, then the median request
    task automatic run_sequence(input int unsigned first_n, input int unsigned second_n,
                                input bit ordered, input int unsigned flavor);
        int first_vals[$];
        int second_vals[$];
        for (int k = 0; k < first_n; k++)
            first_vals.push_back(draw_value(flavor));
        for (int k = 0; k < second_n; k++)
            second_vals.push_back(draw_value(flavor));
        if (ordered) begin
            first_vals.sort();
            second_vals.sort();
        end
        while (first_vals.size() + second_vals.size() != 0) begin
            if ($urandom_range(19) == 0)
                send_word(OP_UNUSED, $urandom);
            if (second_vals.size() == 0 || (first_vals.size() != 0 && $urandom_range(1)))
                send_word(OP_APPEND_FIRST, first_vals.pop_front());
            else
                send_word(OP_APPEND_SECOND, second_vals.pop_front());
        end
        send_word(OP_MEDIAN, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_start;
        int unsigned pick;
        int unsigned longest;

        tracker        = new;
        send_gap_pct   = 20;
        recv_stall_pct = 60;
        words_sent     = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: both stores empty
        send_word(OP_MEDIAN, 0);
        // unused code gives nothing
        send_word(OP_UNUSED, INT_MAX_V);
        // top of the range, even total
        send_word(OP_APPEND_FIRST, INT_MAX_V);
        send_word(OP_APPEND_SECOND, INT_MAX_V);
        send_word(OP_MEDIAN, INT_MIN_V);
        // bottom of the range, single element in the first store
        send_word(OP_APPEND_FIRST, INT_MIN_V);
        send_word(OP_MEDIAN, 0);
        // only the second store, odd total with ties
        send_word(OP_APPEND_SECOND, INT_MIN_V);
        send_word(OP_APPEND_SECOND, INT_MIN_V);
        send_word(OP_APPEND_SECOND, 7);
        send_word(OP_MEDIAN, -1);
        // unsorted first store
        send_word(OP_APPEND_FIRST, 9);
        send_word(OP_APPEND_FIRST, -5);
        send_word(OP_APPEND_SECOND, 0);
        send_word(OP_APPEND_SECOND, 3);
        send_word(OP_MEDIAN, 0);
        // equal lengths, unused word in the middle
        send_word(OP_APPEND_FIRST, 0);
        send_word(OP_UNUSED, -1);
        send_word(OP_APPEND_SECOND, -1);
        send_word(OP_MEDIAN, -1);
        // opposite extremes summed
        send_word(OP_APPEND_FIRST, INT_MIN_V);
        send_word(OP_APPEND_SECOND, INT_MAX_V);
        send_word(OP_MEDIAN, INT_MAX_V);

        // sender holds off until the block has drained
        drain_results();

        // random phases: sender light and receiver heavy, then the reverse,
        // then both channels at full rate
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
            recv_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;

            // overrun the first store by a few elements, sorted content
            if (phase == 0)
                run_sequence(STORE_DEPTH + $urandom_range(3, 1), $urandom_range(5), 1'b1,
                             $urandom_range(2));

            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                pick    = $urandom_range(99);
                longest = (pick < 10) ? 40 : 12;
                if (pick < 4)
                    run_sequence(0, 0, 1'b1, 0);
                else
                    run_sequence($urandom_range(longest), $urandom_range(longest),
                                 $urandom_range(9) != 0, $urandom_range(2));
            end
            drain_results();
        end

        // settle past the last search, then report
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.awaited.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, tracker.awaited.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/mosa_pkg.sv
design/mosa_ram.sv
design/mosa_ctrl.sv
design/mosa_dp.sv
design/median_of_two_sorted_arrays_top.sv
sim/tb_top.sv
